[hw/rtl/assert_macros.svh]
// assertion helpers, empty under synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SFGR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("sfgr check failed");
`define SFGR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfgr check failed");
`else
`define SFGR_ASSERT(lbl, prop)
`define SFGR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[hw/rtl/sfgr_pkg.sv]
`default_nettype none

package sfgr_pkg;

    localparam int FRAC_BITS = 16;
    localparam int FIELD_W   = 17;
    localparam int SHAPE_W   = 18;
    localparam int CFG_W     = 18;
    localparam int CURVE_W   = 20;

    localparam logic [FIELD_W-1:0] ONE  = FIELD_W'(1) << FRAC_BITS;
    localparam logic [FIELD_W-1:0] HALF = FIELD_W'(1) << (FRAC_BITS - 1);

    typedef enum logic [1:0] {
        CFG_SYMMETRIC_MODE = 2'd0,
        CFG_POSITION_STEP  = 2'd1,
        CFG_CURVE_SHAPE    = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [FIELD_W-1:0] target_gain;
        logic               restart_shape;
    } in_word_t;

    typedef struct packed {
        logic [FIELD_W-1:0] gain_out;
        logic               fade_done;
    } out_word_t;

    typedef enum logic [3:0] {
        OP_NONE       = 4'd0,
        OP_LOAD       = 4'd1,
        OP_MOVE       = 4'd2,
        OP_LK_SCALE   = 4'd3,
        OP_LK_IDX     = 4'd4,
        OP_LK_RD0     = 4'd5,
        OP_LK_RD1     = 4'd6,
        OP_LK_MUL     = 4'd7,
        OP_LK_SUM     = 4'd8,
        OP_BL_A       = 4'd9,
        OP_BL_B       = 4'd10,
        OP_SYM_GAIN   = 4'd11,
        OP_ASYM_APPLY = 4'd12,
        OP_FINISH     = 4'd13
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   lk_upper;
    } dp_cmd_t;

    typedef struct packed {
        logic sym;
        logic shaped;
        logic out_busy;
    } dp_status_t;

endpackage

`default_nettype wire

[hw/rtl/shaped_fade_gain_ramp.sv]
// channel   direction  handshake              word
// in        input      in_valid / in_ready    target_gain, restart_shape
// out       output     out_valid / out_ready  gain_out, fade_done
// cfg       input      cfg_write              cfg_index, cfg_data
//
// a word occupies the sequencer from accept until it is back to ready; each curve lookup is six steps
// through the single registered table read port: symmetric shaped words make one lookup,
// asymmetric shaped words two, unshaped words none
// reset is immediate, tables are constants, no clearing pass
// a stalled output word holds the sequencer in its last step; the next input word
// is taken while a finished word waits in the output register
`default_nettype none

module shaped_fade_gain_ramp #(
    parameter int CURVE_TABLE_DEPTH = 256
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire sfgr_pkg::in_word_t         in_word,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output sfgr_pkg::out_word_t             out_word,
    input  wire logic                       cfg_write,
    input  wire logic [1:0]                 cfg_index,
    input  wire logic [sfgr_pkg::CFG_W-1:0] cfg_data
);

    sfgr_pkg::dp_cmd_t    cmd;
    sfgr_pkg::dp_status_t sts;

    sfgr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    sfgr_datapath #(
        .CURVE_TABLE_DEPTH (CURVE_TABLE_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_word   (in_word),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_word  (out_word)
    );

endmodule

`default_nettype wire

[hw/rtl/sfgr_ctrl.sv]
`default_nettype none

`include "assert_macros.svh"

module sfgr_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    output sfgr_pkg::dp_cmd_t         cmd,
    input  wire sfgr_pkg::dp_status_t sts
);

    typedef enum logic [12:0] {
        ST_IDLE       = 13'b0000000000001,
        ST_MOVE       = 13'b0000000000010,
        ST_LK_SCALE   = 13'b0000000000100,
        ST_LK_IDX     = 13'b0000000001000,
        ST_LK_RD0     = 13'b0000000010000,
        ST_LK_RD1     = 13'b0000000100000,
        ST_LK_MUL     = 13'b0000001000000,
        ST_LK_SUM     = 13'b0000010000000,
        ST_BL_A       = 13'b0000100000000,
        ST_BL_B       = 13'b0001000000000,
        ST_SYM_GAIN   = 13'b0010000000000,
        ST_ASYM_APPLY = 13'b0100000000000,
        ST_FINISH     = 13'b1000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   second_reg;
    logic   second_next;

    always_comb
    begin
        state_next  = state_reg;
        second_next = second_reg;
        in_ready    = 1'b0;
        cmd.op      = sfgr_pkg::OP_NONE;
        cmd.lk_upper = !sts.sym && !second_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op      = sfgr_pkg::OP_LOAD;
                    second_next = 1'b0;
                    if (sts.sym)
                        state_next = ST_MOVE;
                    else if (sts.shaped)
                        state_next = ST_LK_SCALE;
                    else
                        state_next = ST_ASYM_APPLY;
                end
            end
            ST_MOVE:
            begin
                cmd.op     = sfgr_pkg::OP_MOVE;
                state_next = sts.shaped ? ST_LK_SCALE : ST_SYM_GAIN;
            end
            ST_LK_SCALE:
            begin
                cmd.op     = sfgr_pkg::OP_LK_SCALE;
                state_next = ST_LK_IDX;
            end
            ST_LK_IDX:
            begin
                cmd.op     = sfgr_pkg::OP_LK_IDX;
                state_next = ST_LK_RD0;
            end
            ST_LK_RD0:
            begin
                cmd.op     = sfgr_pkg::OP_LK_RD0;
                state_next = ST_LK_RD1;
            end
            ST_LK_RD1:
            begin
                cmd.op     = sfgr_pkg::OP_LK_RD1;
                state_next = ST_LK_MUL;
            end
            ST_LK_MUL:
            begin
                cmd.op     = sfgr_pkg::OP_LK_MUL;
                state_next = ST_LK_SUM;
            end
            ST_LK_SUM:
            begin
                cmd.op = sfgr_pkg::OP_LK_SUM;
                if (sts.sym || second_reg)
                    state_next = ST_BL_A;
                else
                begin
                    second_next = 1'b1;
                    state_next  = ST_LK_SCALE;
                end
            end
            ST_BL_A:
            begin
                cmd.op     = sfgr_pkg::OP_BL_A;
                state_next = ST_BL_B;
            end
            ST_BL_B:
            begin
                cmd.op     = sfgr_pkg::OP_BL_B;
                state_next = sts.sym ? ST_SYM_GAIN : ST_ASYM_APPLY;
            end
            ST_SYM_GAIN:
            begin
                cmd.op     = sfgr_pkg::OP_SYM_GAIN;
                state_next = ST_FINISH;
            end
            ST_ASYM_APPLY:
            begin
                cmd.op     = sfgr_pkg::OP_ASYM_APPLY;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!sts.out_busy)
                begin
                    cmd.op     = sfgr_pkg::OP_FINISH;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            second_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            second_reg <= second_next;
        end
    end

    `SFGR_ASSERT(a_state_onehot, $onehot(state_reg))
    `SFGR_ASSERT_NEXT(a_accept_leaves_idle, in_valid && in_ready, !in_ready)
    `SFGR_ASSERT_NEXT(a_finish_holds, state_reg == ST_FINISH && sts.out_busy, state_reg == ST_FINISH)

endmodule

`default_nettype wire

[hw/rtl/sfgr_datapath.sv]
`default_nettype none

`include "assert_macros.svh"

module sfgr_datapath #(
    parameter int CURVE_TABLE_DEPTH = 256
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire sfgr_pkg::dp_cmd_t     cmd,
    output sfgr_pkg::dp_status_t       sts,
    input  wire sfgr_pkg::in_word_t    in_word,
    input  wire logic                  cfg_write,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [sfgr_pkg::CFG_W-1:0] cfg_data,
    input  wire logic                  out_ready,
    output logic                       out_valid,
    output sfgr_pkg::out_word_t        out_word
);

    localparam int FB    = sfgr_pkg::FRAC_BITS;
    localparam int FW    = sfgr_pkg::FIELD_W;
    localparam int HW    = sfgr_pkg::SHAPE_W;
    localparam int CW    = sfgr_pkg::CURVE_W;
    localparam int AW    = $clog2(CURVE_TABLE_DEPTH + 1);
    localparam int SW    = FW + 1 + AW;
    localparam int PW    = FW + SW;
    localparam int ACC_W = CW + FW + 1;
    localparam int DLW   = ACC_W - FB;
    localparam int HP_BITS = 28;

    localparam logic [FW-1:0] ONE      = sfgr_pkg::ONE;
    localparam logic [FW-1:0] HALF     = sfgr_pkg::HALF;
    localparam logic [AW-1:0] LAST_IDX = AW'(CURVE_TABLE_DEPTH - 1);
    localparam logic [63:0]   ONE_HP   = 64'd1 << HP_BITS;

    // e^w, w and result in Q28
    function automatic logic [63:0] exp_hp(input logic [63:0] w);
        logic [63:0] sum;
        logic [63:0] term;
        int          k;
        sum  = ONE_HP;
        term = ONE_HP;
        for (k = 1; k < 120; k++)
        begin
            if (term != 64'd0)
            begin
                term = ((term * w) >> HP_BITS) / 64'(k);
                sum  = sum + term;
            end
        end
        return sum;
    endfunction

    localparam logic [63:0] EXP_DEN = exp_hp(64'd4 << HP_BITS) - ONE_HP;

    // one table entry of the exp curve, or of its inverse by bisection
    function automatic logic [FW-1:0] curve_entry(input logic use_log, input int i);
        logic [63:0] w;
        logic [63:0] num;
        logic [63:0] v;
        logic [63:0] z;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        int          k;
        if (!use_log)
        begin
            w   = ((64'(i) << 30) + 64'(CURVE_TABLE_DEPTH / 2))
                  / 64'(CURVE_TABLE_DEPTH);
            num = exp_hp(w) - ONE_HP;
            v   = ((num << FB) + (EXP_DEN >> 1)) / EXP_DEN;
        end
        else
        begin
            z  = ONE_HP + (64'(i) * EXP_DEN + 64'(CURVE_TABLE_DEPTH / 2))
                 / 64'(CURVE_TABLE_DEPTH);
            lo = 64'd0;
            hi = 64'd1 << 30;
            for (k = 0; k < 40; k++)
            begin
                if (lo < hi)
                begin
                    mid = (lo + hi + 64'd1) >> 1;
                    if (exp_hp(mid) <= z)
                        lo = mid;
                    else
                        hi = mid - 64'd1;
                end
            end
            v = (lo + (64'd1 << (29 - FB))) >> (30 - FB);
        end
        return (v > 64'(ONE)) ? ONE : v[FW-1:0];
    endfunction

    logic [FW-1:0] exp_rom [0:CURVE_TABLE_DEPTH];
    logic [FW-1:0] log_rom [0:CURVE_TABLE_DEPTH];

    for (genvar gi = 0; gi <= CURVE_TABLE_DEPTH; gi++)
    begin : g_rom
        localparam logic [FW-1:0] EXP_VAL = curve_entry(1'b0, gi);
        localparam logic [FW-1:0] LOG_VAL = curve_entry(1'b1, gi);
        assign exp_rom[gi] = EXP_VAL;
        assign log_rom[gi] = LOG_VAL;
    end

    logic                  sym_reg,   sym_next;
    logic [FW-1:0]         step_reg,  step_next;
    logic signed [HW-1:0]  shape_reg, shape_next;
    logic [FW-1:0]         tgt_reg,   tgt_next;
    logic [FW-1:0]         pos_reg,   pos_next;
    logic [FW-1:0]         gain_reg,  gain_next;
    logic [SW-1:0]         scaled_reg, scaled_next;
    logic                  ge_reg,    ge_next;
    logic [AW-1:0]         lo_reg,    lo_next;
    logic [SW-1:0]         f_reg,     f_next;
    logic [FW-1:0]         rom_data_reg;
    logic [FW-1:0]         t0_reg,    t0_next;
    logic [PW-1:0]         prod_reg,  prod_next;
    logic [CW-1:0]         curve_reg, curve_next;
    logic [CW-1:0]         cprev_reg, cprev_next;
    logic [ACC_W-1:0]      acc_reg,   acc_next;
    logic                  out_valid_reg, out_valid_next;
    sfgr_pkg::out_word_t   out_word_reg,  out_word_next;

    logic [FW-1:0]  step_sat;
    logic [HW-1:0]  shape_abs;
    logic [FW-1:0]  mag;
    logic           shaped;
    logic           use_exp;
    logic [FW-1:0]  tgt_in_sat;
    logic [FW-1:0]  move_pos;
    logic [FW:0]    lk_addr;
    logic [AW-1:0]  idx_lo;
    logic [AW-1:0]  rd_addr;
    logic [FW-1:0]  diff;
    logic [PW-1:0]  curve_sum;
    logic [FW-1:0]  blend_x;
    logic [CW-1:0]  blend_y;
    logic [DLW-1:0] delta;
    logic [FW:0]    pos_adv;
    logic [FW-1:0]  asym_gain;
    logic           asym_adv;

    always_comb
    begin
        step_sat   = (step_reg > ONE) ? ONE : step_reg;
        shape_abs  = shape_reg[HW-1] ? HW'(-shape_reg) : HW'(shape_reg);
        mag        = (shape_abs > HW'(ONE)) ? ONE : shape_abs[FW-1:0];
        shaped     = (shape_reg != '0);
        use_exp    = shaped && !shape_reg[HW-1];
        tgt_in_sat = (in_word.target_gain > ONE) ? ONE : in_word.target_gain;

        // symmetric position step toward the target
        if (tgt_reg < pos_reg)
            move_pos = ((pos_reg - tgt_reg) > step_sat) ? pos_reg - step_sat : tgt_reg;
        else if (tgt_reg > pos_reg)
            move_pos = ((tgt_reg - pos_reg) > step_sat) ? pos_reg + step_sat : tgt_reg;
        else
            move_pos = pos_reg;

        // curve lookup address, extrapolates past 1.0 on the last segment
        lk_addr   = cmd.lk_upper ? {1'b0, pos_reg} + {1'b0, step_sat} : {1'b0, pos_reg};
        idx_lo    = ge_reg ? LAST_IDX : scaled_reg[FB +: AW];
        rd_addr   = (cmd.op == sfgr_pkg::OP_LK_RD1) ? lo_reg + AW'(1) : lo_reg;
        diff      = rom_data_reg - t0_reg;
        curve_sum = (prod_reg + PW'(HALF)) >> FB;

        blend_x = sym_reg ? pos_reg : step_sat;
        blend_y = sym_reg ? curve_reg : cprev_reg - curve_reg;
        delta   = shaped ? acc_reg[ACC_W-1:FB] : DLW'(step_sat);

        // asymmetric gain step, clamped at the target
        asym_gain = gain_reg;
        asym_adv  = 1'b1;
        if (tgt_reg > gain_reg)
        begin
            if (delta > DLW'(tgt_reg - gain_reg))
            begin
                asym_gain = tgt_reg;
                asym_adv  = 1'b0;
            end
            else
                asym_gain = gain_reg + delta[FW-1:0];
        end
        else if (tgt_reg < gain_reg)
        begin
            if (delta > DLW'(gain_reg - tgt_reg))
            begin
                asym_gain = tgt_reg;
                asym_adv  = 1'b0;
            end
            else
                asym_gain = gain_reg - delta[FW-1:0];
        end
        pos_adv = {1'b0, pos_reg} + {1'b0, step_sat};
    end

    always_comb
    begin
        sym_next    = sym_reg;
        step_next   = step_reg;
        shape_next  = shape_reg;
        tgt_next    = tgt_reg;
        pos_next    = pos_reg;
        gain_next   = gain_reg;
        scaled_next = scaled_reg;
        ge_next     = ge_reg;
        lo_next     = lo_reg;
        f_next      = f_reg;
        t0_next     = t0_reg;
        prod_next   = prod_reg;
        curve_next  = curve_reg;
        cprev_next  = cprev_reg;
        acc_next    = acc_reg;

        if (cfg_write)
        begin
            case (cfg_index)
                sfgr_pkg::CFG_SYMMETRIC_MODE: sym_next   = cfg_data[0];
                sfgr_pkg::CFG_POSITION_STEP:  step_next  = cfg_data[FW-1:0];
                sfgr_pkg::CFG_CURVE_SHAPE:    shape_next = $signed(cfg_data[HW-1:0]);
                default: ;
            endcase
        end

        case (cmd.op)
            sfgr_pkg::OP_LOAD:
            begin
                tgt_next = tgt_in_sat;
                if (in_word.restart_shape)
                    pos_next = '0;
            end
            sfgr_pkg::OP_MOVE:
            begin
                pos_next = move_pos;
            end
            sfgr_pkg::OP_LK_SCALE:
            begin
                scaled_next = SW'(lk_addr) * SW'(CURVE_TABLE_DEPTH);
                ge_next     = (lk_addr >= {1'b0, ONE});
            end
            sfgr_pkg::OP_LK_IDX:
            begin
                lo_next = idx_lo;
                f_next  = scaled_reg - (SW'(idx_lo) << FB);
            end
            sfgr_pkg::OP_LK_RD1:
            begin
                t0_next = rom_data_reg;
            end
            sfgr_pkg::OP_LK_MUL:
            begin
                prod_next = PW'(diff) * PW'(f_reg);
            end
            sfgr_pkg::OP_LK_SUM:
            begin
                curve_next = CW'(t0_reg) + CW'(curve_sum);
                cprev_next = curve_reg;
            end
            sfgr_pkg::OP_BL_A:
            begin
                acc_next = ACC_W'(blend_x) * ACC_W'(ONE - mag);
            end
            sfgr_pkg::OP_BL_B:
            begin
                acc_next = acc_reg + ACC_W'(blend_y) * ACC_W'(mag) + ACC_W'(HALF);
            end
            sfgr_pkg::OP_SYM_GAIN:
            begin
                gain_next = (shaped && pos_reg != tgt_reg) ? acc_reg[FB +: FW] : pos_reg;
            end
            sfgr_pkg::OP_ASYM_APPLY:
            begin
                gain_next = asym_gain;
                if (asym_adv)
                    pos_next = (pos_adv > {1'b0, ONE}) ? ONE : pos_adv[FW-1:0];
            end
            default: ;
        endcase

        out_valid_next = out_valid_reg && !out_ready;
        out_word_next  = out_word_reg;
        if (cmd.op == sfgr_pkg::OP_FINISH)
        begin
            out_valid_next          = 1'b1;
            out_word_next.gain_out  = gain_reg;
            out_word_next.fade_done = (gain_reg == tgt_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sym_reg       <= 1'b0;
            step_reg      <= ONE;
            shape_reg     <= '0;
            pos_reg       <= '0;
            gain_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sym_reg       <= sym_next;
            step_reg      <= step_next;
            shape_reg     <= shape_next;
            pos_reg       <= pos_next;
            gain_reg      <= gain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tgt_reg      <= tgt_next;
        scaled_reg   <= scaled_next;
        ge_reg       <= ge_next;
        lo_reg       <= lo_next;
        f_reg        <= f_next;
        t0_reg       <= t0_next;
        prod_reg     <= prod_next;
        curve_reg    <= curve_next;
        cprev_reg    <= cprev_next;
        acc_reg      <= acc_next;
        out_word_reg <= out_word_next;
        rom_data_reg <= use_exp ? exp_rom[rd_addr] : log_rom[rd_addr];
    end

    always_comb
    begin
        sts.sym      = sym_reg;
        sts.shaped   = shaped;
        sts.out_busy = out_valid_reg && !out_ready;
    end

    assign out_valid    = out_valid_reg;
    assign out_word     = out_word_reg;

    `SFGR_ASSERT(a_pos_le_one, pos_reg <= ONE)
    `SFGR_ASSERT(a_gain_le_one, gain_reg <= ONE)
    `SFGR_ASSERT_NEXT(a_finish_sets_valid, cmd.op == sfgr_pkg::OP_FINISH, out_valid_reg)

endmodule

`default_nettype wire

[test/tb_shaped_fade_gain_ramp.sv]
`default_nettype none

module tb_shaped_fade_gain_ramp;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int              FW          = sfgr_pkg::FIELD_W;
    localparam int              CFW         = sfgr_pkg::CFG_W;
    localparam int              FRAC        = sfgr_pkg::FRAC_BITS;
    localparam logic [FW-1:0]   FULL        = sfgr_pkg::ONE;
    localparam longint unsigned Q_ONE       = 64'd1 << FRAC;
    localparam longint unsigned Q28_ONE     = 64'd1 << 28;
    localparam int              CURVE_DEPTH = 256;
    localparam int              LOG_CURVE   = 0;
    localparam int              EXP_CURVE   = 1;
    localparam int              CYCLE_LIMIT = 1000000;
    localparam int              REPORT_MAX  = 10;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    sfgr_pkg::in_word_t    in_word = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    sfgr_pkg::out_word_t   out_word;
    logic                  cfg_write = 1'b0;
    logic [1:0]            cfg_index = '0;
    logic [CFW-1:0]        cfg_data = '0;

    shaped_fade_gain_ramp dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow of the block's settings and fade state
    logic                    sym_mode_cfg = 1'b0;
    logic [FW-1:0]           step_cfg = FULL;
    logic signed [sfgr_pkg::SHAPE_W-1:0] shape_cfg = '0;
    longint unsigned         fade_gain = 0;
    longint unsigned         fade_position = 0;
    longint unsigned         curve_tab [0:1][0:CURVE_DEPTH];

    sfgr_pkg::out_word_t expected_words [$];
    bit          gaps_on = 1'b1;
    bit          last_done = 1'b0;
    int unsigned stall_left = 0;
    int unsigned cycle_count = 0;
    int unsigned error_count = 0;
    int unsigned mismatch_count = 0;
    int unsigned words_checked = 0;
    int unsigned sym_ticks = 0;
    int unsigned asym_ticks = 0;
    int unsigned fades_reached = 0;
    int unsigned reg_writes = 0;
    int unsigned drain_pauses = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words still due", cycle_count,
                     expected_words.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (!gaps_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(8, 50);
    endfunction

    // e^w with w in q28, result in q28
    function automatic longint unsigned exp_q28(input longint unsigned w);
        longint unsigned sum;
        longint unsigned term;
        longint unsigned k;
        sum = Q28_ONE;
        term = Q28_ONE;
        for (k = 1; k < 120 && term != 0; k++)
        begin
            term = ((term * w) >> 28) / k;
            sum += term;
        end
        return sum;
    endfunction

    task automatic build_curves();
        longint unsigned den;
        longint unsigned w;
        longint unsigned num;
        longint unsigned v;
        longint unsigned z;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned i;
        den = exp_q28(64'd4 << 28) - Q28_ONE;
        for (i = 0; i <= CURVE_DEPTH; i++)
        begin
            w = ((i << 30) + CURVE_DEPTH / 2) / CURVE_DEPTH;
            num = exp_q28(w) - Q28_ONE;
            v = ((num << FRAC) + den / 2) / den;
            curve_tab[EXP_CURVE][i] = (v > Q_ONE) ? Q_ONE : v;
            z = Q28_ONE + (i * den + CURVE_DEPTH / 2) / CURVE_DEPTH;
            lo = 0;
            hi = 64'd1 << 30;
            while (lo < hi)
            begin
                mid = (lo + hi + 1) / 2;
                if (exp_q28(mid) <= z)
                    lo = mid;
                else
                    hi = mid - 1;
            end
            v = (lo + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
            curve_tab[LOG_CURVE][i] = (v > Q_ONE) ? Q_ONE : v;
        end
    endtask

    // interpolated curve value, last segment extended past 1.0
    function automatic longint unsigned curve_value(input int sel, input longint unsigned a);
        longint unsigned diff;
        longint unsigned scaled;
        longint unsigned idx;
        longint unsigned frac;
        if (a >= Q_ONE)
        begin
            diff = curve_tab[sel][CURVE_DEPTH] - curve_tab[sel][CURVE_DEPTH-1];
            return curve_tab[sel][CURVE_DEPTH]
                   + ((diff * (a - Q_ONE) * CURVE_DEPTH + Q_ONE / 2) >> FRAC);
        end
        scaled = a * CURVE_DEPTH;
        idx = scaled >> FRAC;
        frac = scaled & (Q_ONE - 1);
        if (idx >= CURVE_DEPTH)
            return curve_tab[sel][CURVE_DEPTH];
        return curve_tab[sel][idx]
               + (((curve_tab[sel][idx+1] - curve_tab[sel][idx]) * frac + Q_ONE / 2)
                  >> FRAC);
    endfunction

    function automatic longint unsigned mix_q(input longint unsigned a,
                                              input longint unsigned b,
                                              input longint unsigned s);
        return (a * (Q_ONE - s) + b * s + Q_ONE / 2) >> FRAC;
    endfunction

    // one sample tick of the fade, updates the shadow state
    function automatic sfgr_pkg::out_word_t advance_fade(input sfgr_pkg::in_word_t w);
        sfgr_pkg::out_word_t result;
        longint unsigned t;
        longint unsigned stp;
        longint unsigned mag;
        longint unsigned p;
        longint unsigned g;
        longint unsigned g0;
        longint unsigned delta;
        longint unsigned cd;
        longint          sh;
        int              sel;
        bit              advance;
        t = w.target_gain;
        if (t > Q_ONE)
            t = Q_ONE;
        stp = step_cfg;
        if (stp > Q_ONE)
            stp = Q_ONE;
        sh = shape_cfg;
        sel = (sh > 0) ? EXP_CURVE : LOG_CURVE;
        if (w.restart_shape)
            fade_position = 0;
        mag = (sh < 0) ? -sh : sh;
        if (mag > Q_ONE)
            mag = Q_ONE;
        p = fade_position;
        if (sym_mode_cfg)
        begin
            sym_ticks++;
            if (t < p)
                p = (p - t > stp) ? p - stp : t;
            else if (t > p)
                p = (t - p > stp) ? p + stp : t;
            fade_position = p;
            g = p;
            if (p != t && sh != 0)
                g = mix_q(p, curve_value(sel, p), mag);
            fade_gain = g;
        end
        else
        begin
            asym_ticks++;
            g0 = fade_gain;
            delta = stp;
            advance = 1'b1;
            if (sh != 0)
            begin
                cd = curve_value(sel, p + stp) - curve_value(sel, p);
                delta = (stp * (Q_ONE - mag) + cd * mag + Q_ONE / 2) >> FRAC;
            end
            g = g0;
            if (t > g0)
            begin
                if (delta > t - g0)
                begin
                    g = t;
                    advance = 1'b0;
                end
                else
                    g = g0 + delta;
            end
            else if (t < g0)
            begin
                if (delta > g0 - t)
                begin
                    g = t;
                    advance = 1'b0;
                end
                else
                    g = g0 - delta;
            end
            if (advance)
            begin
                p += stp;
                if (p > Q_ONE)
                    p = Q_ONE;
                fade_position = p;
            end
            fade_gain = g;
        end
        result.gain_out = g[FW-1:0];
        result.fade_done = (g == t);
        last_done = result.fade_done;
        if (result.fade_done)
            fades_reached++;
        return result;
    endfunction

    always @(negedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            stall_left = pick_gap();
            out_ready <= (stall_left == 0);
        end
    end

    always @(posedge clk)
    begin : check_output
        sfgr_pkg::out_word_t want;
        if (rst_n && out_valid === 1'b1 && out_ready)
        begin
            if (expected_words.size() == 0)
            begin
                error_count++;
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("%0t: unexpected word gain %0d done %0b", $realtime,
                             out_word.gain_out, out_word.fade_done);
            end
            else
            begin
                want = expected_words.pop_front();
                words_checked++;
                if (out_word.gain_out !== want.gain_out
                    || out_word.fade_done !== want.fade_done)
                begin
                    error_count++;
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("%0t: word %0d gain exp %0d got %0d, done exp %0b got %0b",
                                 $realtime, words_checked, want.gain_out,
                                 out_word.gain_out, want.fade_done, out_word.fade_done);
                end
            end
        end
    end

    task automatic send_tick(input logic [FW-1:0] target, input logic restart);
        int unsigned        gap;
        sfgr_pkg::in_word_t w;
        w.target_gain = target;
        w.restart_shape = restart;
        gap = pick_gap();
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word <= w;
        do @(posedge clk); while (in_ready !== 1'b1);
        expected_words.push_back(advance_fade(w));
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        drain_pauses++;
    endtask

    task automatic write_reg(input sfgr_pkg::cfg_index_t idx, input logic [CFW-1:0] data);
        drain_results();
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            sfgr_pkg::CFG_SYMMETRIC_MODE: sym_mode_cfg = data[0];
            sfgr_pkg::CFG_POSITION_STEP:  step_cfg = data[FW-1:0];
            sfgr_pkg::CFG_CURVE_SHAPE:    shape_cfg = data;
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic test_default_config();
        send_tick(FULL, 1'b0);
        send_tick('0, 1'b0);
        // target above 1.0 saturates
        send_tick({FW{1'b1}}, 1'b1);
        send_tick('0, 1'b1);
    endtask

    task automatic test_symmetric_fade();
        write_reg(sfgr_pkg::CFG_SYMMETRIC_MODE, 18'd1);
        write_reg(sfgr_pkg::CFG_POSITION_STEP, 18'd16384);
        write_reg(sfgr_pkg::CFG_CURVE_SHAPE, 18'd65536);
        send_tick(FULL, 1'b1);
        send_tick(FULL, 1'b0);
        send_tick(FULL, 1'b0);
        // most negative shape, magnitude saturates on the log curve
        write_reg(sfgr_pkg::CFG_CURVE_SHAPE, 18'h20000);
        send_tick(FULL, 1'b1);
        send_tick(FULL, 1'b0);
        write_reg(sfgr_pkg::CFG_POSITION_STEP, 18'd0);
        send_tick('0, 1'b0);
        // step above 1.0 saturates
        write_reg(sfgr_pkg::CFG_POSITION_STEP, 18'h1FFFF);
        send_tick('0, 1'b0);
        send_tick('0, 1'b0);
    endtask

    task automatic test_asymmetric_fade();
        write_reg(sfgr_pkg::CFG_SYMMETRIC_MODE, 18'd0);
        write_reg(sfgr_pkg::CFG_POSITION_STEP, 18'd40000);
        write_reg(sfgr_pkg::CFG_CURVE_SHAPE, 18'd65536);
        // second and third ticks look up the curve past 1.0
        send_tick(FULL, 1'b1);
        send_tick(FULL, 1'b0);
        send_tick(FULL, 1'b0);
        // tiny increments round to zero
        write_reg(sfgr_pkg::CFG_CURVE_SHAPE, 18'h1FFFF);
        write_reg(sfgr_pkg::CFG_POSITION_STEP, 18'd1);
        send_tick('0, 1'b1);
        send_tick('0, 1'b0);
        write_reg(sfgr_pkg::CFG_CURVE_SHAPE, 18'h30000);
        write_reg(sfgr_pkg::CFG_POSITION_STEP, 18'd65536);
        send_tick(FULL, 1'b1);
    endtask

    task automatic test_mode_switch();
        write_reg(sfgr_pkg::CFG_POSITION_STEP, 18'd8192);
        write_reg(sfgr_pkg::CFG_CURVE_SHAPE, 18'd30000);
        send_tick('0, 1'b1);
        send_tick('0, 1'b0);
        // state carries over into symmetric mode
        write_reg(sfgr_pkg::CFG_SYMMETRIC_MODE, 18'd1);
        send_tick('0, 1'b0);
        send_tick(FULL, 1'b0);
    endtask

    task automatic randomize_settings();
        logic [CFW-1:0] shape_val;
        logic [FW-1:0]  step_val;
        int unsigned    r;
        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            case ($urandom_range(0, 3))
                0: step_val = '0;
                1: step_val = FW'(1);
                2: step_val = FULL;
                default: step_val = {FW{1'b1}};
            endcase
        end
        else if (r < 7)
            step_val = FW'($urandom_range(512, 16384));
        else if (r < 9)
            step_val = FW'($urandom_range(16384, 65536));
        else
            step_val = FW'($urandom_range(1, 131071));
        r = $urandom_range(0, 9);
        if (r < 2)
        begin
            case ($urandom_range(0, 4))
                0: shape_val = 18'h20000;
                1: shape_val = 18'h30000;
                2: shape_val = '0;
                3: shape_val = 18'h10000;
                default: shape_val = 18'h1FFFF;
            endcase
        end
        else if (r < 6)
            shape_val = CFW'($urandom_range(0, 131072) - 65536);
        else
            shape_val = CFW'($urandom);
        write_reg(sfgr_pkg::CFG_SYMMETRIC_MODE, CFW'($urandom_range(0, 1)));
        write_reg(sfgr_pkg::CFG_POSITION_STEP, CFW'(step_val));
        write_reg(sfgr_pkg::CFG_CURVE_SHAPE, shape_val);
    endtask

    // fades toward goals that are mostly zero or full scale, with some noise words mixed in
    task automatic run_fades(input int unsigned n_words);
        logic [FW-1:0] goal;
        logic          rearm;
        int unsigned   dwell;
        int unsigned   k;
        goal = ($urandom_range(0, 1) != 0) ? FULL : '0;
        rearm = 1'b1;
        dwell = $urandom_range(0, 6);
        for (k = 0; k < n_words; k++)
        begin
            if ($urandom_range(0, 99) < 2)
                drain_results();
            if ($urandom_range(0, 9) == 0)
                send_tick(FW'($urandom), 1'($urandom_range(0, 1)));
            else
            begin
                send_tick(goal, rearm);
                rearm = 1'b0;
            end
            if ((last_done && dwell == 0) || $urandom_range(0, 99) == 0)
            begin
                if ($urandom_range(0, 9) < 7)
                    goal = (goal == FULL) ? '0 : FULL;
                else
                    goal = FW'($urandom_range(0, 65536));
                rearm = ($urandom_range(0, 4) != 0);
                dwell = $urandom_range(0, 6);
            end
            else if (last_done)
                dwell--;
        end
    endtask

    task automatic test_random_fades();
        int unsigned phase;
        for (phase = 0; phase < 16; phase++)
        begin
            gaps_on = (phase % 4 != 3);
            randomize_settings();
            run_fades(116);
        end
        gaps_on = 1'b1;
    endtask

    initial
    begin
        build_curves();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_default_config();
        test_symmetric_fade();
        test_asymmetric_fade();
        test_mode_switch();
        test_random_fades();
        drain_results();
        repeat (40) @(posedge clk);
        if (expected_words.size() != 0)
        begin
            error_count++;
            $display("%0d expected words never arrived", expected_words.size());
        end
        $display("checked %0d words: %0d symmetric and %0d asymmetric ticks, %0d at target",
                 words_checked, sym_ticks, asym_ticks, fades_reached);
        $display("%0d register writes, %0d drain pauses, %0d mismatches",
                 reg_writes, drain_pauses, mismatch_count);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
+incdir+hw/rtl
hw/rtl/sfgr_pkg.sv
hw/rtl/sfgr_ctrl.sv
hw/rtl/sfgr_datapath.sv
hw/rtl/shaped_fade_gain_ramp.sv
test/tb_shaped_fade_gain_ramp.sv
